// ----- hdl/afr_pkg.sv -----
// Shared types, codes and sample conversion for the ADC sample frame ring.
package afr_pkg;

  localparam int RawW     = 12;
  localparam int PcmW     = 16;
  localparam int BiasW    = 12;
  localparam int FlenW    = 11;
  localparam int IdxW     = 10;
  localparam int OvfW     = 32;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 12;
  localparam int PcmShift = 4;
  localparam int CentW    = RawW + 2;

  localparam logic [FlenW-1:0]        FrameLenReset = 11'd640;
  localparam logic signed [CentW-1:0] RawCenter     = 14'sd2048;
  localparam logic signed [CentW-1:0] CentHigh      = 14'sd2047;
  localparam logic signed [CentW-1:0] CentLow       = -14'sd2048;
  localparam logic signed [PcmW-1:0]  PcmMax        = 16'sd32767;
  localparam logic signed [PcmW-1:0]  PcmMin        = -16'sd32768;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_FRAME  = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DC_BIAS   = 1'd0,
    CFG_FRAME_LEN = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [RawW-1:0] raw_sample;
    logic [IdxW-1:0] word_index;
  } in_item_t;

  typedef struct packed {
    logic signed [PcmW-1:0] pcm_value;
    logic signed [PcmW-1:0] read_data;
    logic [1:0]             frames_pending;
    logic [OvfW-1:0]        overflow_total;
    logic [1:0]             status;
  } out_item_t;

  // Per-transaction ring decision, valid in the cycle of acceptance.
  typedef struct packed {
    logic            wr_en;
    logic            rd_en;
    status_e         status;
    logic [1:0]      pending;
    logic [OvfW-1:0] overflow;
  } ring_op_t;

  // Center, add bias, scale by 16 and saturate to the PCM range.
  function automatic logic signed [PcmW-1:0] conv_sample(
    input logic [RawW-1:0]         raw,
    input logic signed [BiasW-1:0] bias
  );
    logic signed [CentW-1:0] cent;
    logic signed [PcmW-1:0]  res;
    cent = $signed({2'b00, raw}) - RawCenter + CentW'(bias);
    if (cent > CentHigh) begin
      res = PcmMax;
    end else if (cent < CentLow) begin
      res = PcmMin;
    end else begin
      res = $signed({cent[PcmW-PcmShift-1:0], {PcmShift{1'b0}}});
    end
    return res;
  endfunction

endpackage

// ----- hdl/afr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module afr_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/afr_ring.sv -----
// Ring pointers, pending count and overflow counter; forms RAM addresses.
module afr_ring #(
  parameter int SlotCount = 4,
  parameter int FrameMax  = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  go_i,
  input  logic [1:0]                            cmd_i,
  input  logic [afr_pkg::IdxW-1:0]              word_index_i,
  input  logic [afr_pkg::FlenW-1:0]             frame_len_i,
  output afr_pkg::ring_op_t                     op_o,
  output logic [$clog2(SlotCount*FrameMax)-1:0] waddr_o,
  output logic [$clog2(SlotCount*FrameMax)-1:0] raddr_o
);
  import afr_pkg::*;

  localparam int SlotW = $clog2(SlotCount);
  localparam int OffW  = $clog2(FrameMax);
  localparam int LenW  = $clog2(FrameMax + 1);
  localparam int AddrW = $clog2(SlotCount * FrameMax);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(SlotCount - 1);

  logic [SlotW-1:0] wslot_q, wslot_d, rslot_q, rslot_d;
  logic [SlotW-1:0] pend_q, pend_d;
  logic [OffW-1:0]  woff_q, woff_d;
  logic [OvfW-1:0]  ovf_q, ovf_d;
  logic [LenW-1:0]  len;
  logic             frame_done;
  logic             idx_bad;
  status_e          status;
  logic             wr_en, rd_en;

  always_comb begin
    if (frame_len_i == '0) begin
      len = LenW'(1);
    end else if (32'(frame_len_i) > FrameMax) begin
      len = LenW'(FrameMax);
    end else begin
      len = LenW'(frame_len_i);
    end
  end

  assign frame_done = (LenW'(woff_q) + LenW'(1)) >= len;
  assign idx_bad    = 32'(word_index_i) >= 32'(len);

  always_comb begin
    wslot_d = wslot_q;
    rslot_d = rslot_q;
    pend_d  = pend_q;
    woff_d  = woff_q;
    ovf_d   = ovf_q;
    status  = STAT_OK;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    unique case (cmd_i)
      CMD_SAMPLE: begin
        wr_en = go_i;
        if (frame_done) begin
          woff_d = '0;
          if (pend_q < LastSlot) begin
            wslot_d = (wslot_q == LastSlot) ? '0 : wslot_q + 1'b1;
            pend_d  = pend_q + 1'b1;
          end else begin
            ovf_d = ovf_q + 1'b1;
          end
        end else begin
          woff_d = woff_q + 1'b1;
        end
      end
      CMD_READ: begin
        if (pend_q == '0) begin
          status = STAT_NO_FRAME;
        end else if (idx_bad) begin
          status = STAT_BAD_INDEX;
        end else begin
          rd_en = go_i;
        end
      end
      CMD_RELEASE: begin
        if (pend_q == '0) begin
          status = STAT_NO_FRAME;
        end else begin
          rslot_d = (rslot_q == LastSlot) ? '0 : rslot_q + 1'b1;
          pend_d  = pend_q - 1'b1;
        end
      end
      default: begin
        status = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q <= '0;
      rslot_q <= '0;
      pend_q  <= '0;
      woff_q  <= '0;
      ovf_q   <= '0;
    end else if (go_i) begin
      wslot_q <= wslot_d;
      rslot_q <= rslot_d;
      pend_q  <= pend_d;
      woff_q  <= woff_d;
      ovf_q   <= ovf_d;
    end
  end

  assign waddr_o = AddrW'(32'(wslot_q) * FrameMax) + AddrW'(woff_q);
  assign raddr_o = AddrW'(32'(rslot_q) * FrameMax) + AddrW'(word_index_i);

  assign op_o.wr_en    = wr_en;
  assign op_o.rd_en    = rd_en;
  assign op_o.status   = status;
  assign op_o.pending  = 2'(pend_d);
  assign op_o.overflow = ovf_d;

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pend_q) <= SlotCount - 1)
    else $error("pending frame count beyond ring capacity");

  a_ovf_only_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(go_i && cmd_i == CMD_SAMPLE) |=> $stable(ovf_q))
    else $error("overflow counter moved without a sample");

  a_rd_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (pend_q != '0) && !wr_en)
    else $error("RAM read issued with no frame pending");

endmodule

// ----- hdl/adc_sample_frame_ring.sv -----
// Top level of the ADC sample frame ring: handshake stages, config, RAM.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------
//  in       | in_valid_i / in_ready_o    | in_data_i  (in_item_t)
//  out      | out_valid_o / out_ready_i  | out_data_o (out_item_t)
//  cfg      | cfg_we_i (no wait)         | cfg_idx_i, cfg_wdata_i
//
// Each transaction is held in the issue stage while the frame RAM read, which is
// registered, completes, and then lands in the output register, so
// out_valid_o rises once the issue stage has advanced into it. One transaction is accepted
// per cycle while the output side keeps up; the single RAM port pair sets
// that rate. Reset clears pointers, counters and both stage valids; the
// frame RAM holds whatever it held. A stalled output holds the issue stage,
// which in turn drops in_ready_o.
module adc_sample_frame_ring #(
  parameter int SlotCount = 4,
  parameter int FrameMax  = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  afr_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output afr_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [afr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [afr_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import afr_pkg::*;

  localparam int Depth = SlotCount * FrameMax;
  localparam int AddrW = $clog2(Depth);

  logic signed [BiasW-1:0] dc_bias_q;
  logic [FlenW-1:0]        frame_len_q;

  logic                    accept;
  logic                    s1_adv;
  logic                    s1_valid_q;
  out_item_t               s1_item_q;
  logic                    s1_rd_q;
  logic                    out_valid_q;
  out_item_t               out_item_q;
  out_item_t               out_item_d;

  ring_op_t                op;
  logic [AddrW-1:0]        waddr, raddr;
  logic signed [PcmW-1:0]  pcm;
  logic [PcmW-1:0]         rdata;

  // Configuration registers; the user must write them only while the block is quiet (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_bias_q   <= '0;
      frame_len_q <= FrameLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DC_BIAS:   dc_bias_q   <= $signed(cfg_wdata_i[BiasW-1:0]);
        CFG_FRAME_LEN: frame_len_q <= cfg_wdata_i[FlenW-1:0];
        default: begin
          dc_bias_q <= dc_bias_q;
        end
      endcase
    end
  end

  // Issue stage advances whenever the output register is free or draining.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  assign pcm = (in_data_i.cmd == CMD_SAMPLE) ?
               conv_sample(in_data_i.raw_sample, dc_bias_q) : '0;

  afr_ring #(
    .SlotCount(SlotCount),
    .FrameMax (FrameMax)
  ) u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (accept),
    .cmd_i        (in_data_i.cmd),
    .word_index_i (in_data_i.word_index),
    .frame_len_i  (frame_len_q),
    .op_o         (op),
    .waddr_o      (waddr),
    .raddr_o      (raddr)
  );

  // Writes and reads never share a transaction, and a read always comes after
  // the write it depends on, so no forwarding is needed.
  afr_ram #(
    .Width(PcmW),
    .Depth(Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (op.wr_en),
    .waddr_i (waddr),
    .wdata_i (pcm),
    .re_i    (op.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Issue stage: hold everything but the read word, which the RAM supplies.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_q                  <= op.rd_en;
      s1_item_q.pcm_value      <= pcm;
      s1_item_q.read_data      <= '0;
      s1_item_q.frames_pending <= op.pending;
      s1_item_q.overflow_total <= op.overflow;
      s1_item_q.status         <= op.status;
    end
  end

  // Merge the RAM word into the held result.
  always_comb begin
    out_item_d           = s1_item_q;
    out_item_d.read_data = s1_rd_q ? $signed(rdata) : '0;
  end

  // Output register: load from the issue stage, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  a_accept_fills_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted transaction missing from issue stage");

  a_issue_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("issue stage advanced but output register empty");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while both stages are full and stalled");

endmodule
